// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the pressed key set tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, muted while rst_n is low
`define PKST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next cycle check: cons must hold in the cycle after ante, muted while rst_n is low
`define PKST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pkst_pkg.sv =====
// shared constants and types of the pressed key set tracker
`timescale 1ns / 1ps

package pkst_pkg;

  localparam int KEY_CODES = 256;
  localparam int MAX_HELD  = 64;
  localparam int ADDR_W    = $clog2(KEY_CODES);
  localparam int HELD_W    = $clog2(MAX_HELD + 1);
  localparam int CODE_W    = 8;

  localparam logic [CODE_W-1:0] ROUTING_BASE_RST = 8'd80;

  typedef logic [CODE_W-1:0] code_t;

  typedef enum logic {
    MODE_KEY = 1'b0,
    MODE_END = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    EV_RELEASE = 2'd0,
    EV_PRESS   = 2'd1,
    EV_DROP    = 2'd2
  } ev_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // one entry of the key store
  typedef struct packed {
    logic held;
    logic seen;
  } entry_t;

endpackage

// ===== rtl/pkst_ram.sv =====
// simple dual port ram, one write port and one registered read port
`timescale 1ns / 1ps

module pkst_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pressed_key_set_tracker_core.sv =====
// top level of the pressed key set tracker
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Tracks which keys are held across key reports. Each key byte is one item,
// an end-of-report item closes the report. All key state sits in one store
// of KEY_CODES entries (held and seen-this-report bits) with a registered
// read, so a key byte that needs the store is read, then modified and
// written back, and a press or drop also waits while the result is stalled;
// a zero byte or a byte after the list ended does not touch the store.
// The end item walks the whole store one entry per cycle while the result
// side does not stall, emitting releases and clearing the seen bits. After
// reset the store is cleared by a pass over all KEY_CODES entries (256),
// during which no item is accepted; the routing_base register can be
// written at any idle time, including then.
module pressed_key_set_tracker_core (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_key_code,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic       out_key_group,
  output logic [7:0] out_key_index,
  output logic       out_last,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int AW = pkst_pkg::ADDR_W;
  localparam int HW = pkst_pkg::HELD_W;

  pkst_pkg::state_t  state_r, state_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              list_ended_r, list_ended_nxt;
  logic [HW-1:0]     held_count_r, held_count_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  pkst_pkg::code_t   pend_code_r, pend_code_nxt;
  pkst_pkg::code_t   base_r;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic              out_group_r;
  pkst_pkg::code_t   out_index_r;
  logic              out_last_r;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  pkst_pkg::entry_t  mem_wdata, mem_q;
  logic [1:0]        mem_rdata;

  logic                 push, push_last;
  pkst_pkg::ev_kind_t   push_kind;
  pkst_pkg::code_t      push_code;
  logic                 push_group;
  pkst_pkg::code_t      push_index;
  logic                 out_free;
  logic                 release_hit;

  pkst_ram #(
    .DEPTH(pkst_pkg::KEY_CODES),
    .WIDTH(2)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign mem_q       = pkst_pkg::entry_t'(mem_rdata);
  assign out_free    = !out_valid_r || !out_stall;
  assign release_hit = mem_q.held && !mem_q.seen;
  assign cfg_ready   = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    list_ended_nxt = list_ended_r;
    held_count_nxt = held_count_r;
    pend_valid_nxt = pend_valid_r;
    pend_code_nxt  = pend_code_r;
    in_stall       = 1'b1;
    mem_re         = 1'b0;
    mem_raddr      = addr_r;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = '0;
    push           = 1'b0;
    push_last      = 1'b0;
    push_kind      = pkst_pkg::EV_RELEASE;
    push_code      = pkst_pkg::CODE_W'(addr_r);

    case (state_r)
      pkst_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == AW'(pkst_pkg::KEY_CODES - 1)) begin
          addr_nxt  = '0;
          state_nxt = pkst_pkg::ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      pkst_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_mode == pkst_pkg::MODE_END) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            addr_nxt  = '0;
            state_nxt = pkst_pkg::ST_SCAN;
          end else if (!list_ended_r) begin
            if (in_key_code == '0) begin
              list_ended_nxt = 1'b1;
            end else if (int'(in_key_code) < pkst_pkg::KEY_CODES) begin
              mem_re    = 1'b1;
              mem_raddr = in_key_code[AW-1:0];
              addr_nxt  = in_key_code[AW-1:0];
              state_nxt = pkst_pkg::ST_KEY;
            end
          end
        end
      end

      pkst_pkg::ST_KEY: begin
        if (mem_q.seen) begin
          state_nxt = pkst_pkg::ST_IDLE;
        end else if (mem_q.held) begin
          mem_we    = 1'b1;
          mem_wdata = '{held: 1'b1, seen: 1'b1};
          state_nxt = pkst_pkg::ST_IDLE;
        end else if (out_free) begin
          mem_we    = 1'b1;
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = pkst_pkg::ST_IDLE;
          if (held_count_r < HW'(pkst_pkg::MAX_HELD)) begin
            push_kind      = pkst_pkg::EV_PRESS;
            mem_wdata      = '{held: 1'b1, seen: 1'b1};
            held_count_nxt = held_count_r + 1'b1;
          end else begin
            push_kind = pkst_pkg::EV_DROP;
            mem_wdata = '{held: 1'b0, seen: 1'b1};
          end
        end
      end

      pkst_pkg::ST_SCAN: begin
        // a release is held back in the pending register so the final one can carry last
        if (!(release_hit && pend_valid_r && !out_free)) begin
          mem_we    = 1'b1;
          mem_wdata = '{held: mem_q.held && mem_q.seen, seen: 1'b0};
          if (release_hit) begin
            held_count_nxt = held_count_r - 1'b1;
            pend_valid_nxt = 1'b1;
            pend_code_nxt  = pkst_pkg::CODE_W'(addr_r);
            if (pend_valid_r) begin
              push      = 1'b1;
              push_code = pend_code_r;
            end
          end
          if (addr_r == AW'(pkst_pkg::KEY_CODES - 1)) begin
            state_nxt = pkst_pkg::ST_FLUSH;
          end else begin
            addr_nxt  = addr_r + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = addr_r + 1'b1;
          end
        end
      end

      pkst_pkg::ST_FLUSH: begin
        if (!pend_valid_r) begin
          list_ended_nxt = 1'b0;
          state_nxt      = pkst_pkg::ST_IDLE;
        end else if (out_free) begin
          push           = 1'b1;
          push_last      = 1'b1;
          push_code      = pend_code_r;
          pend_valid_nxt = 1'b0;
          list_ended_nxt = 1'b0;
          state_nxt      = pkst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pkst_pkg::ST_IDLE;
      end
    endcase
  end

  // group split against the routing base
  always_comb begin
    push_group = (push_code >= base_r);
    push_index = push_group ? (push_code - base_r) : push_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pkst_pkg::ST_CLEAR;
      addr_r       <= '0;
      list_ended_r <= 1'b0;
      held_count_r <= '0;
      pend_valid_r <= 1'b0;
      base_r       <= pkst_pkg::ROUTING_BASE_RST;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      list_ended_r <= list_ended_nxt;
      held_count_r <= held_count_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_code_r <= pend_code_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind_r  <= push_kind;
      out_group_r <= push_group;
      out_index_r <= push_index;
      out_last_r  <= push_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_key_group  = out_group_r;
  assign out_key_index  = out_index_r;
  assign out_last       = out_last_r;

  `PKST_ASSERT(a_held_cap, held_count_r <= HW'(pkst_pkg::MAX_HELD), "held count above capacity")
  `PKST_ASSERT(a_pend_scope, pend_valid_r |-> (state_r == pkst_pkg::ST_SCAN || state_r == pkst_pkg::ST_FLUSH), "pending release outside scan")
  `PKST_ASSERT_NEXT(a_press_count, push && push_kind == pkst_pkg::EV_PRESS, held_count_r == $past(held_count_r) + 1'b1, "press without held count step")
  `PKST_ASSERT_NEXT(a_flush_exit, state_r == pkst_pkg::ST_FLUSH && state_nxt == pkst_pkg::ST_IDLE, !pend_valid_r && !list_ended_r, "report end left state behind")

endmodule
